// ----- rtl/mecanum_wheel_mixer_assert.svh -----
// Assertion macros shared by the mecanum wheel mixer RTL.
// Depends on nothing; the files that check their own logic include it.
`ifndef MECANUM_WHEEL_MIXER_ASSERT_SVH
`define MECANUM_WHEEL_MIXER_ASSERT_SVH

`ifndef SYNTH

// Same-cycle implication, disabled while reset is high.
`define MWM_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define MWM_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define MWM_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg)
`define MWM_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

// ----- rtl/mwm_pkg.sv -----
// Package of the mecanum wheel mixer: field widths, fixed-point constants,
// register indexes and the divider stage type. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package mwm_pkg;

   // Q1.15 command and Q0.16 gain widths.
   localparam int CMD_W  = 16;
   localparam int GAIN_W = 16;

   // Wheel sums are exact Q.31 values; their magnitude stays below 3.0.
   localparam int SUM_W = 34;
   localparam int MAG_W = SUM_W - 1;

   // Quotient of |sum| * 2^16 / divisor, at most 2^16.
   localparam int QUO_W = 17;

   localparam int NUM_WHEELS = 4;

   // 1.0 in the Q.31 sum format.
   localparam logic [MAG_W-1:0] ONE_Q31 = MAG_W'(64'h8000_0000);

   // Configuration register indexes.
   localparam int CSR_IDX_W = 1;
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FORWARD_GAIN = 1'b0,
      CSR_ROTATE_GAIN  = 1'b1
   } csr_index_type;

   localparam logic [GAIN_W-1:0] FORWARD_GAIN_RESET = 16'd32768;
   localparam logic [GAIN_W-1:0] ROTATE_GAIN_RESET  = 16'd16384;

   typedef logic signed [SUM_W-1:0] sum_type;
   typedef logic [MAG_W-1:0]        mag_type;
   typedef logic [QUO_W-1:0]        quo_type;

   // One stage of the four-lane restoring divider.
   typedef struct packed {
      logic [NUM_WHEELS-1:0][MAG_W-1:0] rem;
      logic [NUM_WHEELS-1:0][QUO_W-1:0] quo;
      logic [NUM_WHEELS-1:0]            neg;
      logic [MAG_W-1:0]                 div;
      logic                             norm;
   } div_stage_type;

endpackage

`default_nettype wire

// ----- rtl/mwm_req_if.sv -----
// Request channel of the mecanum wheel mixer: one drive command.
// Depends on mwm_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface mwm_req_if import mwm_pkg::*;;

   logic                    valid;
   logic                    ready;
   logic signed [CMD_W-1:0] strafe;
   logic signed [CMD_W-1:0] drive_y;
   logic signed [CMD_W-1:0] rotate;

   modport source (output valid, output strafe, output drive_y, output rotate,
                   input ready);
   modport sink   (input valid, input strafe, input drive_y, input rotate,
                   output ready);

endinterface

`default_nettype wire

// ----- rtl/mwm_rsp_if.sv -----
// Response channel of the mecanum wheel mixer: four wheel commands and a flag.
// Depends on mwm_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface mwm_rsp_if import mwm_pkg::*;;

   logic                    valid;
   logic                    ready;
   logic signed [CMD_W-1:0] front_left_cmd;
   logic signed [CMD_W-1:0] front_right_cmd;
   logic signed [CMD_W-1:0] rear_left_cmd;
   logic signed [CMD_W-1:0] rear_right_cmd;
   logic                    normalized;

   modport source (output valid, output front_left_cmd, output front_right_cmd,
                   output rear_left_cmd, output rear_right_cmd, output normalized,
                   input ready);
   modport sink   (input valid, input front_left_cmd, input front_right_cmd,
                   input rear_left_cmd, input rear_right_cmd, input normalized,
                   output ready);

endinterface

`default_nettype wire

// ----- rtl/mecanum_wheel_mixer.sv -----
// Mecanum wheel mixer: inverse kinematics from one drive command to four
// wheel commands, with normalization when any wheel exceeds full scale.
//
// Channels: req_ch takes strafe, drive_y and rotate (signed Q1.15);
// rsp_ch returns the four wheel commands (signed Q1.15, right side negated,
// saturated) and the normalized flag. Both use valid/ready; a request moves
// at a clock edge where valid and ready are both high. The csr_ port writes
// forward_gain (index 0) and rotate_gain (index 1) as Q0.16 values; the user
// must see that it is written only while no request is in flight, as the
// block itself does not enforce this.
//
// One request is accepted every cycle while the receiver does not stall; a
// 17-stage restoring divider resolves one quotient bit per stage in all four
// wheel lanes at once.
//
// Reset clears every stage valid bit and loads the default gains (0.5 and
// 0.25); there is no clearing pass. When the receiver stalls, each stage
// holds its item, empty stages keep filling, and req_ch.ready falls only
// once every stage holds an item.
`timescale 1ns / 1ps
`default_nettype none
`include "mecanum_wheel_mixer_assert.svh"

module mecanum_wheel_mixer import mwm_pkg::*; (
   input  wire                  clock,
   input  wire                  reset,
   mwm_req_if.sink              req_ch,
   mwm_rsp_if.source            rsp_ch,
   input  wire                  csr_we,
   input  wire [CSR_IDX_W-1:0]  csr_index,
   input  wire [GAIN_W-1:0]     csr_wdata
);

   // Stage map: products, sums, magnitudes, pair maxima, divisor select,
   // one stage per quotient bit, then the output register.
   localparam int ST_DIV0 = 4;
   localparam int ST_OUT  = ST_DIV0 + QUO_W + 1;
   localparam int NSTG    = ST_OUT + 1;

   // Wheels on the right side are negated at the output.
   localparam logic [NUM_WHEELS-1:0] RIGHT_SIDE = 4'b1010;

   // Saturate a rounded, signed command to Q1.15.
   function automatic logic signed [CMD_W-1:0] sat_cmd(input logic signed [CMD_W+1:0] v);
      logic signed [CMD_W-1:0] r;
      if (v > $signed((CMD_W+2)'(32767))) begin
         r = 16'sh7FFF;
      end else if (v < -$signed((CMD_W+2)'(32768))) begin
         r = 16'sh8000;
      end else begin
         r = v[CMD_W-1:0];
      end
      return r;
   endfunction

   // ---------------------------------------------------------------
   // Configuration registers.
   // ---------------------------------------------------------------
   logic [GAIN_W-1:0] forward_gain_ff;
   logic [GAIN_W-1:0] rotate_gain_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         forward_gain_ff <= FORWARD_GAIN_RESET;
         rotate_gain_ff  <= ROTATE_GAIN_RESET;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_FORWARD_GAIN: forward_gain_ff <= csr_wdata;
            CSR_ROTATE_GAIN:  rotate_gain_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------
   // Pipeline control: a stage takes a new item when it is empty or
   // when its own item moves on.
   // ---------------------------------------------------------------
   logic [NSTG-1:0] v_ff;
   logic [NSTG-1:0] v_in;
   logic [NSTG-1:0] adv;

   assign adv[NSTG-1]  = !v_ff[NSTG-1] || rsp_ch.ready;
   assign v_in[0]      = req_ch.valid;
   assign req_ch.ready = adv[0];

   for (genvar i = 0; i < NSTG - 1; i++) begin : g_ctl
      assign adv[i]    = !v_ff[i] || adv[i+1];
      assign v_in[i+1] = v_ff[i];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int i = 0; i < NSTG; i++) begin
            if (adv[i]) begin
               v_ff[i] <= v_in[i];
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // Stage 0: the three scaled axes in Q.31.
   // ---------------------------------------------------------------
   sum_type right_ff, fwd_ff, cw_ff;
   sum_type right_in, fwd_in, cw_in;
   logic signed [CMD_W:0] neg_y;
   logic signed [CMD_W:0] rot_x;
   logic signed [CMD_W:0] fg_x;
   logic signed [CMD_W:0] rg_x;

   always_comb begin
      neg_y    = -{req_ch.drive_y[CMD_W-1], req_ch.drive_y};
      rot_x    = {req_ch.rotate[CMD_W-1], req_ch.rotate};
      fg_x     = $signed({1'b0, forward_gain_ff});
      rg_x     = $signed({1'b0, rotate_gain_ff});
      right_in = {{(SUM_W-CMD_W-16){req_ch.strafe[CMD_W-1]}}, req_ch.strafe, 16'h0000};
      fwd_in   = neg_y * fg_x;
      cw_in    = rot_x * rg_x;
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         right_ff <= right_in;
         fwd_ff   <= fwd_in;
         cw_ff    <= cw_in;
      end
   end

   // ---------------------------------------------------------------
   // Stage 1: the four wheel sums.
   // ---------------------------------------------------------------
   sum_type sum_ff [NUM_WHEELS];
   sum_type sum_in [NUM_WHEELS];

   always_comb begin
      sum_in[0] = fwd_ff + cw_ff + right_ff;
      sum_in[1] = fwd_ff - cw_ff - right_ff;
      sum_in[2] = fwd_ff + cw_ff - right_ff;
      sum_in[3] = fwd_ff - cw_ff + right_ff;
   end

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         sum_ff <= sum_in;
      end
   end

   // ---------------------------------------------------------------
   // Stage 2: sign and magnitude of each sum.
   // ---------------------------------------------------------------
   mag_type               mag2_ff [NUM_WHEELS];
   mag_type               mag2_in [NUM_WHEELS];
   logic [NUM_WHEELS-1:0] neg2_ff, neg2_in;

   always_comb begin
      for (int w = 0; w < NUM_WHEELS; w++) begin
         neg2_in[w] = sum_ff[w][SUM_W-1];
         mag2_in[w] = neg2_in[w] ? MAG_W'(-sum_ff[w]) : MAG_W'(sum_ff[w]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv[2]) begin
         mag2_ff <= mag2_in;
         neg2_ff <= neg2_in;
      end
   end

   // ---------------------------------------------------------------
   // Stage 3: maximum magnitude of each wheel pair.
   // ---------------------------------------------------------------
   mag_type               mag3_ff [NUM_WHEELS];
   logic [NUM_WHEELS-1:0] neg3_ff;
   mag_type               max01_ff, max23_ff;
   mag_type               max01_in, max23_in;

   always_comb begin
      max01_in = (mag2_ff[0] > mag2_ff[1]) ? mag2_ff[0] : mag2_ff[1];
      max23_in = (mag2_ff[2] > mag2_ff[3]) ? mag2_ff[2] : mag2_ff[3];
   end

   always_ff @(posedge clock) begin
      if (adv[3]) begin
         mag3_ff  <= mag2_ff;
         neg3_ff  <= neg2_ff;
         max01_ff <= max01_in;
         max23_ff <= max23_in;
      end
   end

   // ---------------------------------------------------------------
   // Stage 4: overall maximum and divisor. Without normalization the
   // divisor is 1.0, which gives the plain round-to-nearest shift.
   // ---------------------------------------------------------------
   div_stage_type dstg_ff [QUO_W+1];
   div_stage_type dstg_in [QUO_W+1];
   mag_type       max_all;

   always_comb begin
      max_all         = (max01_ff > max23_ff) ? max01_ff : max23_ff;
      dstg_in[0].norm = max_all > ONE_Q31;
      dstg_in[0].div  = dstg_in[0].norm ? max_all : ONE_Q31;
      dstg_in[0].neg  = neg3_ff;
      dstg_in[0].quo  = '0;
      for (int w = 0; w < NUM_WHEELS; w++) begin
         dstg_in[0].rem[w] = mag3_ff[w];
      end
   end

   // ---------------------------------------------------------------
   // Divider: step k resolves quotient bit QUO_W-1-k of
   // |sum| * 2^16 / divisor. The first step compares without a shift,
   // since the magnitude can equal the divisor.
   // ---------------------------------------------------------------
   for (genvar k = 0; k < QUO_W; k++) begin : g_div
      logic [MAG_W:0] trial [NUM_WHEELS];
      logic [MAG_W:0] diff  [NUM_WHEELS];

      always_comb begin
         dstg_in[k+1] = dstg_ff[k];
         for (int w = 0; w < NUM_WHEELS; w++) begin
            if (k == 0) begin
               trial[w] = {1'b0, dstg_ff[k].rem[w]};
            end else begin
               trial[w] = {dstg_ff[k].rem[w], 1'b0};
            end
            diff[w] = trial[w] - {1'b0, dstg_ff[k].div};
            if (trial[w] >= {1'b0, dstg_ff[k].div}) begin
               dstg_in[k+1].rem[w]            = diff[w][MAG_W-1:0];
               dstg_in[k+1].quo[w][QUO_W-1-k] = 1'b1;
            end else begin
               dstg_in[k+1].rem[w] = trial[w][MAG_W-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k <= QUO_W; k++) begin
         if (adv[ST_DIV0+k]) begin
            dstg_ff[k] <= dstg_in[k];
         end
      end
   end

   // ---------------------------------------------------------------
   // Output stage: round half up on the extra quotient bit, restore the
   // sign, negate the right side and saturate.
   // ---------------------------------------------------------------
   logic signed [CMD_W-1:0] cmd_ff [NUM_WHEELS];
   logic signed [CMD_W-1:0] cmd_in [NUM_WHEELS];
   logic                    norm_ff;

   always_comb begin
      logic [QUO_W:0]          rounded;
      logic signed [CMD_W+1:0] qs;
      logic                    flip;
      for (int w = 0; w < NUM_WHEELS; w++) begin
         rounded   = {1'b0, dstg_ff[QUO_W].quo[w]} + (QUO_W+1)'(1);
         qs        = $signed({1'b0, rounded[QUO_W:1]});
         flip      = dstg_ff[QUO_W].neg[w] ^ RIGHT_SIDE[w];
         cmd_in[w] = sat_cmd(flip ? -qs : qs);
      end
   end

   always_ff @(posedge clock) begin
      if (adv[ST_OUT]) begin
         cmd_ff  <= cmd_in;
         norm_ff <= dstg_ff[QUO_W].norm;
      end
   end

   assign rsp_ch.valid           = v_ff[ST_OUT];
   assign rsp_ch.front_left_cmd  = cmd_ff[0];
   assign rsp_ch.front_right_cmd = cmd_ff[1];
   assign rsp_ch.rear_left_cmd   = cmd_ff[2];
   assign rsp_ch.rear_right_cmd  = cmd_ff[3];
   assign rsp_ch.normalized      = norm_ff;

   // ---------------------------------------------------------------
   // Assertions.
   // ---------------------------------------------------------------

   // An accepted request always lands in the first stage.
   `MWM_ASSERT_NEXT(a_req_enters, clock, reset, req_ch.valid && req_ch.ready, v_ff[0], "request lost at pipeline entry")

   // Without normalization the divisor must be exactly 1.0.
   `MWM_ASSERT_IMPLY(a_unit_div, clock, reset, v_ff[ST_DIV0] && !dstg_ff[0].norm, dstg_ff[0].div == ONE_Q31, "divisor is not 1.0 without normalization")

   // After the last divider step every remainder is below the divisor.
   `MWM_ASSERT_IMPLY(a_rem_bound, clock, reset, v_ff[ST_OUT-1], (dstg_ff[QUO_W].rem[0] < dstg_ff[QUO_W].div) && (dstg_ff[QUO_W].rem[1] < dstg_ff[QUO_W].div) && (dstg_ff[QUO_W].rem[2] < dstg_ff[QUO_W].div) && (dstg_ff[QUO_W].rem[3] < dstg_ff[QUO_W].div), "divider remainder out of range")

   // A normalized response drives its largest wheel at full scale.
   `MWM_ASSERT_IMPLY(a_norm_full, clock, reset, rsp_ch.valid && rsp_ch.normalized, (cmd_ff[0] == 16'sh7FFF) || (cmd_ff[0] == 16'sh8000) || (cmd_ff[1] == 16'sh7FFF) || (cmd_ff[1] == 16'sh8000) || (cmd_ff[2] == 16'sh7FFF) || (cmd_ff[2] == 16'sh8000) || (cmd_ff[3] == 16'sh7FFF) || (cmd_ff[3] == 16'sh8000), "normalized response has no full-scale wheel")

endmodule

`default_nettype wire
